@@ rtl/core/pps_pkg.sv @@
// pps_pkg: shared types and constants of the preemptive priority scheduler
// no dependencies; imported by the controller, datapath, top level and checker
`default_nettype none

package pps_pkg;

  // fixed field widths of the item formats
  localparam int CMD_W     = 2;
  localparam int SLOT_IN_W = 4;
  localparam int ARR_W     = 10;
  localparam int PRI_W     = 8;
  localparam int WORK_W    = 8;
  localparam int TIME_W    = 16;
  localparam int CFG_W     = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // command codes carried on the input tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // one process slot as held in the slot memory
  typedef struct packed {
    logic [ARR_W-1:0]  arrival;
    logic [PRI_W-1:0]  priority_val;
    logic [WORK_W-1:0] work;
  } slot_entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear;
    logic load;
    logic scan_start;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic n_zero;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/pps_ctrl.sv @@
// pps_ctrl: sequencing state machine of the scheduler (accept, scan, compare drain, commit)
// depends on pps_pkg for the command and status structs
`default_nettype none

module pps_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pps_pkg::CMD_W-1:0]     s_cmd,
  input  pps_pkg::dp_sts_t              sts,
  output pps_pkg::dp_cmd_t              cmd
);
  import pps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t state;

  // command decode per state
  always_comb begin
    cmd      = '0;
    s_tready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (cmd_t'(s_cmd))
            CMD_CLEAR: cmd.clear      = 1'b1;
            CMD_LOAD:  cmd.load       = 1'b1;
            CMD_TICK:  cmd.scan_start = 1'b1;
            default:   ;
          endcase
        end
      end
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_DRAIN:  ;
      ST_COMMIT: cmd.commit = sts.out_free;
      default:   ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.scan_start) begin
            state <= sts.n_zero ? ST_COMMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts.scan_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN:  state <= ST_COMMIT;
        ST_COMMIT: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pps_datapath.sv @@
// pps_datapath: slot memory, progress marks, time, best-slot compare and result register
// depends on pps_pkg; driven by pps_ctrl through dp_cmd_t
`default_nettype none

module pps_datapath #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [pps_pkg::CFG_W-1:0]        cfg_data,
  input  logic [pps_pkg::SLOT_IN_W-1:0]    ld_slot,
  input  logic [pps_pkg::ARR_W-1:0]        ld_arrival,
  input  logic [pps_pkg::PRI_W-1:0]        ld_priority,
  input  logic [pps_pkg::WORK_W-1:0]       ld_duration,
  input  pps_pkg::dp_cmd_t                 cmd,
  output pps_pkg::dp_sts_t                 sts,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pps_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [0:0]                       m_tuser
);
  import pps_pkg::*;

  localparam int SLOT_W = $clog2(MAX_PROCESSES);
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CMP_W-1:0] MAX_N = CMP_W'(MAX_PROCESSES);
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic [CFG_W-1:0]          slot_count;
  logic [CMP_W-1:0]          pc_ext;
  logic [CMP_W-1:0]          n_use;
  logic [CMP_W-1:0]          scan_cnt;

  slot_entry_t               slot_mem [MAX_PROCESSES];
  slot_entry_t               rd_q;

  logic [MAX_PROCESSES-1:0]  busy;
  logic [MAX_PROCESSES-1:0]  started_mark;
  logic [MAX_PROCESSES-1:0]  use_mask;
  logic [MAX_PROCESSES-1:0]  best_onehot;
  logic [MAX_PROCESSES-1:0]  busy_after;

  logic [TIME_W-1:0]         now_time;
  logic                      cmp_valid;
  logic [SLOT_W-1:0]         cmp_idx;
  logic                      found;
  logic [SLOT_W-1:0]         best_idx;
  logic [ARR_W-1:0]          best_arr;
  logic [PRI_W-1:0]          best_pri;
  logic [WORK_W-1:0]         best_work;

  logic                      load_ok;
  logic [SLOT_W-1:0]         ld_addr;
  logic                      cand;
  logic                      better;
  logic                      finish;
  logic                      first_run;
  logic                      all_done;
  logic [SLOT_IN_W-1:0]      chosen;

  // slots in use, saturated at MAX_PROCESSES
  assign pc_ext = CMP_W'(slot_count);
  assign n_use  = (pc_ext > MAX_N) ? MAX_N : pc_ext;

  assign load_ok = CMP_W'(ld_slot) < MAX_N;
  assign ld_addr = SLOT_W'(ld_slot);

  // candidate test and ranking against the best so far
  assign cand   = cmp_valid && busy[cmp_idx] && (TIME_W'(rd_q.arrival) <= now_time);
  assign better = !found || (rd_q.priority_val > best_pri) ||
                  ((rd_q.priority_val == best_pri) && (rd_q.arrival < best_arr));

  // outcome of the winning slot
  assign finish      = found && (best_work == WORK_W'(1));
  assign first_run   = found && !started_mark[best_idx];
  assign best_onehot = MAX_PROCESSES'(1) << best_idx;
  assign busy_after  = busy & ~(finish ? best_onehot : '0);
  assign chosen      = found ? SLOT_IN_W'(best_idx) : '0;

  always_comb begin
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      use_mask[i] = CMP_W'(i) < n_use;
    end
  end

  assign all_done = ~|(busy_after & use_mask);

  // status to the controller
  assign sts.n_zero    = (n_use == '0);
  assign sts.scan_last = (scan_cnt == n_use - CMP_W'(1));
  assign sts.out_free  = !m_tvalid || m_tready;

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      slot_mem[ld_addr] <= '{arrival: ld_arrival, priority_val: ld_priority,
                             work: ld_duration};
    end else if (cmd.commit && found) begin
      slot_mem[best_idx] <= '{arrival: best_arr, priority_val: best_pri,
                              work: best_work - WORK_W'(1)};
    end
    rd_q <= slot_mem[scan_cnt[SLOT_W-1:0]];
  end

  // control state: config, progress marks, time, scan and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= CFG_W'(1);
      busy          <= '0;
      started_mark  <= '0;
      now_time      <= '0;
      scan_cnt      <= '0;
      cmp_valid     <= 1'b0;
      found         <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        slot_count <= cfg_data;
      end

      // clear, load and commit never coincide
      if (cmd.clear) begin
        busy         <= '0;
        started_mark <= '0;
        now_time     <= '0;
      end else if (cmd.load && load_ok) begin
        busy[ld_addr]         <= (ld_duration != '0);
        started_mark[ld_addr] <= 1'b0;
      end else if (cmd.commit) begin
        busy <= busy_after;
        if (found) begin
          started_mark[best_idx] <= 1'b1;
        end
        if (now_time != TIME_MAX) begin
          now_time <= now_time + TIME_W'(1);
        end
      end

      // scan counter and compare pipeline
      cmp_valid <= cmd.scan_step;
      if (cmd.scan_start) begin
        scan_cnt <= '0;
        found    <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_cnt <= scan_cnt + CMP_W'(1);
      end
      if (cand && better) begin
        found <= 1'b1;
      end

      // result register
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx <= scan_cnt[SLOT_W-1:0];
    if (cand && better) begin
      best_idx  <= cmp_idx;
      best_arr  <= rd_q.arrival;
      best_pri  <= rd_q.priority_val;
      best_work <= rd_q.work;
    end
    if (cmd.commit) begin
      m_tdata <= {1'b0, all_done, finish, first_run, chosen, now_time};
      m_tuser <= !found;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/preemptive_priority_scheduler_unit.sv @@
// Preemptive priority scheduler, top level.
// Input stream: s_tuser carries the command (clear, load slot, tick); s_tdata carries
// the load fields. Only tick items produce a result on the master stream; clear, load
// and unknown commands are absorbed with no result.
// Config channel: cfg_valid/cfg_ready writes the slot count, always ready; write only
// while the block is idle.
// A tick scans the slots in use one per cycle through the slot memory read port, then
// a drain state finishes the last compare and a commit state registers the result; the
// next item is taken only after the commit. With no slot in use the scan is skipped and
// the tick goes straight to commit.
// The result sits in an output register, so clear and load items keep being taken
// while it waits; a further tick waits in its commit cycle until the register frees.
// Reset: slot count 1, time zero, no slot busy, no start marks, no result pending.
// Arrival and priority entries are not cleared; they are only read for loaded slots.
// A stalled receiver holds m_tvalid and the result stable until taken.
// Depends on pps_pkg, pps_ctrl, pps_datapath.
`default_nettype none

module preemptive_priority_scheduler_unit #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // slot[3:0], arrival[13:4], priority_req[21:14], duration[29:22], zero[31:30]
  input  logic [pps_pkg::IN_DATA_W-1:0]      s_tdata,
  // cmd[1:0]
  input  logic [pps_pkg::CMD_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tick_time[15:0], chosen[19:16], started[20], finished[21], all_done[22], zero[23]
  output logic [pps_pkg::OUT_DATA_W-1:0]     m_tdata,
  // idle[0]
  output logic [0:0]                         m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pps_pkg::CFG_W-1:0]          cfg_data
);
  import pps_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    s_accept_ok;

  // config register always takes a write
  assign cfg_ready   = 1'b1;
  assign s_accept_ok = s_tready;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_cmd    (s_tuser),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  pps_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .ld_slot     (s_tdata[SLOT_IN_W-1:0]),
    .ld_arrival  (s_tdata[SLOT_IN_W +: ARR_W]),
    .ld_priority (s_tdata[SLOT_IN_W+ARR_W +: PRI_W]),
    .ld_duration (s_tdata[SLOT_IN_W+ARR_W+PRI_W +: WORK_W]),
    .cmd         (dp_cmd & {$bits(dp_cmd_t){s_accept_ok | !dp_cmd.load}}),
    .sts         (dp_sts),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

@@ rtl/core/pps_checker.sv @@
// pps_checker: port-level assertions for the scheduler top level, bound in below
// depends on pps_pkg and preemptive_priority_scheduler_unit
`default_nettype none

module pps_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [pps_pkg::CMD_W-1:0]          s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [pps_pkg::OUT_DATA_W-1:0]     m_tdata,
  input logic [0:0]                         m_tuser
);
  import pps_pkg::*;

  // an idle tick names no slot and raises no start or finish flag
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[19:16] == 4'd0) && !m_tdata[20] && !m_tdata[21])
    else $error("idle result carries slot or flags");

  // a slot that ran without finishing still has work, so not all done
  a_busy_not_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && !m_tdata[21] |-> !m_tdata[22])
    else $error("all_done raised while chosen slot still has work");

  // a tick item occupies the block for the following cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_TICK) |=> !s_tready)
    else $error("new item taken right after a tick");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (.*);

`default_nettype wire
